@@ rtl/tlpt_pkg.sv @@
// shared types and constants for the two-level page table engine
package tlpt_pkg;

   localparam int DIR_SLOTS_DEFAULT = 64;
   localparam int TBL_IDX_W         = 10;
   localparam int TABLE_LEN         = 1 << TBL_IDX_W;
   localparam int FRAME_W           = 20;
   localparam int ENTRY_W           = FRAME_W + 1;
   localparam int PAGE_SHIFT        = 12;
   localparam int DIR_SHIFT         = PAGE_SHIFT + TBL_IDX_W;
   localparam int ADDR_W            = 32;
   localparam int DIR_IDX_W         = ADDR_W - DIR_SHIFT;

   typedef enum logic [1:0] {
      KIND_LOOKUP    = 2'd0,
      KIND_MAP_FIXED = 2'd1,
      KIND_MAP_NEW   = 2'd2,
      KIND_UNMAP     = 2'd3
   } kind_type;

   // write command from the operation logic to the store
   typedef struct packed {
      logic               dir_we;
      logic               pg_we;
      logic [ENTRY_W-1:0] pg_wdata;
   } store_wr_type;

   // read side of the store
   typedef struct packed {
      logic               ready;
      logic               dir_present;
      logic [ENTRY_W-1:0] pg_entry;
   } store_rd_type;

endpackage

@@ rtl/tlpt_store.sv @@
// directory and page entry memories with the clearing sweep after reset
module tlpt_store
   import tlpt_pkg::*;
#(
   parameter int DIR_SLOTS = DIR_SLOTS_DEFAULT,
   parameter int DIR_AW    = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1,
   parameter int PG_AW     = DIR_AW + TBL_IDX_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [DIR_AW-1:0]  rd_dir_idx,
   input  logic [PG_AW-1:0]   rd_pg_addr,
   input  store_wr_type       wr,
   input  logic [DIR_AW-1:0]  wr_dir_idx,
   input  logic [PG_AW-1:0]   wr_pg_addr,
   output store_rd_type       rd
);

   localparam int PG_DEPTH = DIR_SLOTS * TABLE_LEN;

   logic               dir_mem [DIR_SLOTS];
   logic [ENTRY_W-1:0] pg_mem  [PG_DEPTH];

   logic               clearing_ff;
   logic [PG_AW-1:0]   clr_cnt_ff;
   logic               dir_rd_ff;
   logic [ENTRY_W-1:0] pg_rd_ff;

   logic               dir_we_mux;
   logic               dir_wdata_mux;
   logic [DIR_AW-1:0]  dir_waddr_mux;
   logic               pg_we_mux;
   logic [ENTRY_W-1:0] pg_wdata_mux;
   logic [PG_AW-1:0]   pg_waddr_mux;

   always_comb begin
      if (clearing_ff) begin
         dir_we_mux    = clr_cnt_ff < PG_AW'(DIR_SLOTS);
         dir_wdata_mux = 1'b0;
         dir_waddr_mux = clr_cnt_ff[DIR_AW-1:0];
         pg_we_mux     = 1'b1;
         pg_wdata_mux  = '0;
         pg_waddr_mux  = clr_cnt_ff;
      end else begin
         dir_we_mux    = wr.dir_we;
         dir_wdata_mux = 1'b1;
         dir_waddr_mux = wr_dir_idx;
         pg_we_mux     = wr.pg_we;
         pg_wdata_mux  = wr.pg_wdata;
         pg_waddr_mux  = wr_pg_addr;
      end
   end

   // sweep one page entry per cycle, directory slots on the way
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         if (clr_cnt_ff == PG_AW'(PG_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we_mux) begin
         dir_mem[dir_waddr_mux] <= dir_wdata_mux;
      end
      if (rd_en) begin
         dir_rd_ff <= dir_mem[rd_dir_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pg_we_mux) begin
         pg_mem[pg_waddr_mux] <= pg_wdata_mux;
      end
      if (rd_en) begin
         pg_rd_ff <= pg_mem[rd_pg_addr];
      end
   end

   assign rd.ready       = !clearing_ff;
   assign rd.dir_present = dir_rd_ff;
   assign rd.pg_entry    = pg_rd_ff;

endmodule

@@ rtl/two_level_page_table_engine_top.sv @@
// top level of the two-level page table engine: operation sequencing and result register
//
//   channel  direction  signals                       contents
//   req      in         req_tvalid/tready/tdata/tuser  kind, virt, phys, table addresses
//   rsp      out        rsp_tvalid/tready/tdata        status, flags, translated address
//
// each request is accepted in ST_IDLE, where directory and page entry are
// read from the synchronous memories; in ST_EXEC the operation writes back
// and loads the result register. after reset a clearing pass over all
// DIR_SLOTS*1024 page entries runs before the first request is taken.
// a stalled result holds the operation in ST_EXEC until the result
// register is free.
module two_level_page_table_engine_top
   import tlpt_pkg::*;
#(
   parameter int DIR_SLOTS = DIR_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // virt_addr[31:0], phys_addr[63:32], table_addr[95:64]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // status[0], was_mapped[1], phys_out[33:2],
                                   // used_data_frame[34], used_table_frame[35],
                                   // flush_request[36], zero[39:37]
);

   localparam int DIR_AW = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
   localparam int PG_AW  = DIR_AW + TBL_IDX_W;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type            state_ff;
   kind_type             kind_ff;
   logic [ADDR_W-1:0]    va_ff;
   logic [FRAME_W-1:0]   pa_frame_ff;
   logic                 rsp_valid_ff;
   logic [39:0]          rsp_data_ff;

   store_wr_type         wr;
   store_rd_type         rd;

   logic                 req_fire;
   logic                 exec_fire;
   logic [DIR_IDX_W-1:0] req_di;
   logic [DIR_IDX_W-1:0] di;
   logic [TBL_IDX_W-1:0] ti;
   logic                 in_range;
   logic                 mapped;

   logic                 status;
   logic                 was_mapped;
   logic [ADDR_W-1:0]    phys_out;
   logic                 used_data;
   logic                 used_table;
   logic                 flush;
   logic [39:0]          rsp_data_in;

   assign req_tready = (state_ff == ST_IDLE) && rd.ready;
   assign req_fire   = req_tvalid && req_tready;
   assign req_di     = req_tdata[ADDR_W-1:DIR_SHIFT];

   assign di       = va_ff[ADDR_W-1:DIR_SHIFT];
   assign ti       = va_ff[DIR_SHIFT-1:PAGE_SHIFT];
   assign in_range = {1'b0, di} < (DIR_IDX_W + 1)'(DIR_SLOTS);
   assign mapped   = rd.dir_present && rd.pg_entry[ENTRY_W-1];

   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      status      = 1'b0;
      was_mapped  = 1'b0;
      phys_out    = '0;
      used_data   = 1'b0;
      used_table  = 1'b0;
      flush       = 1'b0;
      wr.dir_we   = 1'b0;
      wr.pg_we    = 1'b0;
      wr.pg_wdata = '0;
      if (!in_range) begin
         status   = 1'b1;
         phys_out = (kind_ff == KIND_LOOKUP) ? '1 : '0;
      end else begin
         case (kind_ff)
            KIND_LOOKUP: begin
               was_mapped = mapped;
               phys_out   = mapped ? {rd.pg_entry[FRAME_W-1:0], {PAGE_SHIFT{1'b0}}} : '1;
            end
            KIND_UNMAP: begin
               if (rd.dir_present) begin
                  was_mapped = mapped;
                  flush      = 1'b1;
                  wr.pg_we   = exec_fire;
               end
            end
            KIND_MAP_FIXED, KIND_MAP_NEW: begin
               if ((kind_ff == KIND_MAP_NEW) && mapped) begin
                  was_mapped = 1'b1;
               end else begin
                  // fresh tables already read as empty from the reset sweep
                  used_table  = !rd.dir_present;
                  wr.dir_we   = exec_fire && !rd.dir_present;
                  wr.pg_we    = exec_fire;
                  wr.pg_wdata = {1'b1, pa_frame_ff};
                  was_mapped  = mapped;
                  used_data   = kind_ff == KIND_MAP_NEW;
                  flush       = 1'b1;
               end
            end
            default: begin
               status = 1'b0;
            end
         endcase
      end
      rsp_data_in = {3'b000, flush, used_table, used_data, phys_out, was_mapped, status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_fire) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= kind_type'(req_tuser);
         va_ff       <= req_tdata[ADDR_W-1:0];
         pa_frame_ff <= req_tdata[2*ADDR_W-1:ADDR_W+PAGE_SHIFT];
      end
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   tlpt_store #(
      .DIR_SLOTS (DIR_SLOTS),
      .DIR_AW    (DIR_AW),
      .PG_AW     (PG_AW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire && ({1'b0, req_di} < (DIR_IDX_W + 1)'(DIR_SLOTS))),
      .rd_dir_idx (req_di[DIR_AW-1:0]),
      .rd_pg_addr ({req_di[DIR_AW-1:0], req_tdata[DIR_SHIFT-1:PAGE_SHIFT]}),
      .wr         (wr),
      .wr_dir_idx (di[DIR_AW-1:0]),
      .wr_pg_addr ({di[DIR_AW-1:0], ti}),
      .rd         (rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted request always moves to the write-back cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted request did not enter write-back");

   // no store write outside a completing operation
   a_write_exec: assert property (@(posedge clock) disable iff (reset)
      (wr.pg_we || wr.dir_we) |-> exec_fire && in_range)
      else $error("store written outside write-back");

   // a created table always comes with a flush and a zero status
   a_table_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[35] |-> rsp_data_ff[36] && !rsp_data_ff[0])
      else $error("table created without flush");

   // out of range never reports a consumed frame or a flush
   a_oor_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[0] |-> rsp_data_ff[36:34] == 3'b000 && !rsp_data_ff[1])
      else $error("out of range result carries side effects");

endmodule
